// ===== rtl/core/clsau_pkg.sv =====
// ----------------------------------------------------------------------------
// clsau_pkg
// Shared constants, codes and helper functions of the load/store addressing
// unit.
// ----------------------------------------------------------------------------
package clsau_pkg;

  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 32'd1);

  localparam logic [2:0] OP_LDA = 3'd0;
  localparam logic [2:0] OP_LDX = 3'd1;
  localparam logic [2:0] OP_LDY = 3'd2;
  localparam logic [2:0] OP_LAX = 3'd3;
  localparam logic [2:0] OP_STA = 3'd4;
  localparam logic [2:0] OP_STX = 3'd5;
  localparam logic [2:0] OP_STY = 3'd6;
  localparam logic [2:0] OP_SAX = 3'd7;

  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ZPY  = 4'd3;
  localparam logic [3:0] MODE_ABS  = 4'd4;
  localparam logic [3:0] MODE_ABSX = 4'd5;
  localparam logic [3:0] MODE_ABSY = 4'd6;
  localparam logic [3:0] MODE_INDX = 4'd7;
  localparam logic [3:0] MODE_INDY = 4'd8;

  // Bit m of an entry is set when mode m is supported for that opcode.
  localparam logic [8:0] SUPPORTED_MODES [8] = '{
    9'h1F7, 9'h05B, 9'h037, 9'h1DA, 9'h1F6, 9'h01A, 9'h016, 9'h09A
  };

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           wdata;
  } mem_req_t;

  function automatic logic op_supported(logic [2:0] op, logic [3:0] mode);
    logic [8:0] modes;
    logic       ok;
    modes = SUPPORTED_MODES[op];
    if (mode > MODE_INDY) begin
      ok = 1'b0;
    end else begin
      ok = modes[mode];
    end
    return ok;
  endfunction

  function automatic logic [1:0] instr_length(logic [3:0] mode);
    logic [1:0] len;
    case (mode)
      MODE_ABS, MODE_ABSX, MODE_ABSY: len = 2'd3;
      default:                        len = 2'd2;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] base_cycles(logic is_load, logic [3:0] mode);
    logic [2:0] cyc;
    case (mode)
      MODE_IMM:                      cyc = is_load ? 3'd2 : 3'd0;
      MODE_ZP:                       cyc = 3'd3;
      MODE_ZPX, MODE_ZPY, MODE_ABS:  cyc = 3'd4;
      MODE_ABSX, MODE_ABSY:          cyc = is_load ? 3'd4 : 3'd5;
      MODE_INDX:                     cyc = 3'd6;
      MODE_INDY:                     cyc = is_load ? 3'd5 : 3'd6;
      default:                       cyc = 3'd0;
    endcase
    return cyc;
  endfunction

endpackage

// ===== rtl/core/clsau_ram.sv =====
// ----------------------------------------------------------------------------
// clsau_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module clsau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/clsau_ctrl.sv =====
// ----------------------------------------------------------------------------
// clsau_ctrl
// Sequencer and register file: resolves the effective address, fetches
// pointer bytes, reads or writes the byte memory and forms the result word.
// ----------------------------------------------------------------------------
module clsau_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          opcode_i,
  input  logic [3:0]          mode_i,
  input  logic [15:0]         operand_i,
  output clsau_pkg::mem_req_t mem_req_o,
  input  logic [7:0]          mem_rdata_i,
  output logic                done_o,
  output logic [7:0]          reg_a_o,
  output logic [7:0]          reg_x_o,
  output logic [7:0]          reg_y_o,
  output logic                zero_flag_o,
  output logic                negative_flag_o,
  output logic                wrote_memory_o,
  output logic [15:0]         write_address_o,
  output logic [7:0]          write_data_o,
  output logic [1:0]          instr_bytes_o,
  output logic [2:0]          cycle_count_o,
  output logic                unsupported_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_PLO  = 3'd2;
  localparam logic [2:0] S_PHI  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [3:0]  mode_q, mode_d;
  logic [15:0] opnd_q, opnd_d;
  logic [7:0]  ptr_zp_q, ptr_zp_d;
  logic [7:0]  ptr_lo_q, ptr_lo_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d;
  logic        z_q, z_d, n_q, n_d;
  logic        done_q, done_d;
  logic        wrote_q, wrote_d;
  logic [15:0] waddr_q, waddr_d;
  logic [7:0]  wdata_q, wdata_d;
  logic [1:0]  bytes_q, bytes_d;
  logic [2:0]  cycles_q, cycles_d;
  logic        unsup_q, unsup_d;

  logic        is_load;
  logic [7:0]  zp;
  logic [7:0]  ptr_zp;
  logic [15:0] ea_dir, ea_ind, ea_m;
  logic [7:0]  store_val, load_val;
  logic        ld_fin, st_fin, un_fin;

  assign is_load = (op_q < clsau_pkg::OP_STA);
  assign zp      = opnd_q[7:0];
  assign ptr_zp  = (mode_q == clsau_pkg::MODE_INDX) ? zp + x_q : zp;

  always_comb begin
    case (mode_q)
      clsau_pkg::MODE_ZP:   ea_dir = {8'h00, zp};
      clsau_pkg::MODE_ZPX:  ea_dir = {8'h00, 8'(zp + x_q)};
      clsau_pkg::MODE_ZPY:  ea_dir = {8'h00, 8'(zp + y_q)};
      clsau_pkg::MODE_ABS:  ea_dir = opnd_q;
      clsau_pkg::MODE_ABSX: ea_dir = opnd_q + {8'h00, x_q};
      clsau_pkg::MODE_ABSY: ea_dir = opnd_q + {8'h00, y_q};
      default:              ea_dir = 16'h0000;
    endcase
  end

  assign ea_ind = (mode_q == clsau_pkg::MODE_INDY) ?
                  {mem_rdata_i, ptr_lo_q} + {8'h00, y_q} : {mem_rdata_i, ptr_lo_q};
  assign ea_m   = ((state_q == S_PHI) ? ea_ind : ea_dir) & clsau_pkg::ADDR_MASK;

  always_comb begin
    case (op_q)
      clsau_pkg::OP_STA: store_val = a_q;
      clsau_pkg::OP_STX: store_val = x_q;
      clsau_pkg::OP_STY: store_val = y_q;
      default:           store_val = a_q & x_q;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mode_d    = mode_q;
    opnd_d    = opnd_q;
    ptr_zp_d  = ptr_zp_q;
    ptr_lo_d  = ptr_lo_q;
    a_d       = a_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    n_d       = n_q;
    done_d    = 1'b0;
    wrote_d   = wrote_q;
    waddr_d   = waddr_q;
    wdata_d   = wdata_q;
    bytes_d   = bytes_q;
    cycles_d  = cycles_q;
    unsup_d   = unsup_q;
    ld_fin    = 1'b0;
    st_fin    = 1'b0;
    un_fin    = 1'b0;
    load_val  = mem_rdata_i;
    mem_req_o = '{we: 1'b0, addr: ea_m[clsau_pkg::ADDR_BITS-1:0], wdata: store_val};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = opcode_i;
          mode_d  = mode_i;
          opnd_d  = operand_i;
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        if (!clsau_pkg::op_supported(op_q, mode_q)) begin
          un_fin = 1'b1;
        end else if (mode_q == clsau_pkg::MODE_IMM) begin
          load_val = zp;
          ld_fin   = 1'b1;
        end else if (mode_q == clsau_pkg::MODE_INDX || mode_q == clsau_pkg::MODE_INDY) begin
          mem_req_o.addr = 16'({8'h00, ptr_zp} & clsau_pkg::ADDR_MASK);
          ptr_zp_d       = ptr_zp;
          state_d        = S_PLO;
        end else if (is_load) begin
          state_d = S_LOAD;
        end else begin
          st_fin = 1'b1;
        end
      end
      S_PLO: begin
        ptr_lo_d       = mem_rdata_i;
        mem_req_o.addr = 16'({8'h00, 8'(ptr_zp_q + 8'd1)} & clsau_pkg::ADDR_MASK);
        state_d        = S_PHI;
      end
      S_PHI: begin
        if (is_load) begin
          state_d = S_LOAD;
        end else begin
          st_fin = 1'b1;
        end
      end
      S_LOAD: begin
        ld_fin = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (ld_fin) begin
      if (op_q == clsau_pkg::OP_LDA || op_q == clsau_pkg::OP_LAX) a_d = load_val;
      if (op_q == clsau_pkg::OP_LDX || op_q == clsau_pkg::OP_LAX) x_d = load_val;
      if (op_q == clsau_pkg::OP_LDY) y_d = load_val;
      z_d      = (load_val == 8'h00);
      n_d      = load_val[7];
      wrote_d  = 1'b0;
      waddr_d  = 16'h0000;
      wdata_d  = 8'h00;
      bytes_d  = clsau_pkg::instr_length(mode_q);
      cycles_d = clsau_pkg::base_cycles(1'b1, mode_q);
      unsup_d  = 1'b0;
    end
    if (st_fin) begin
      mem_req_o.we = 1'b1;
      wrote_d      = 1'b1;
      waddr_d      = ea_m;
      wdata_d      = store_val;
      bytes_d      = clsau_pkg::instr_length(mode_q);
      cycles_d     = clsau_pkg::base_cycles(1'b0, mode_q);
      unsup_d      = 1'b0;
    end
    if (un_fin) begin
      wrote_d  = 1'b0;
      waddr_d  = 16'h0000;
      wdata_d  = 8'h00;
      bytes_d  = 2'd0;
      cycles_d = 3'd0;
      unsup_d  = 1'b1;
    end
    if (ld_fin || st_fin || un_fin) begin
      done_d  = 1'b1;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      a_q     <= 8'h00;
      x_q     <= 8'h00;
      y_q     <= 8'h00;
      z_q     <= 1'b0;
      n_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      a_q     <= a_d;
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    mode_q   <= mode_d;
    opnd_q   <= opnd_d;
    ptr_zp_q <= ptr_zp_d;
    ptr_lo_q <= ptr_lo_d;
    wrote_q  <= wrote_d;
    waddr_q  <= waddr_d;
    wdata_q  <= wdata_d;
    bytes_q  <= bytes_d;
    cycles_q <= cycles_d;
    unsup_q  <= unsup_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign reg_a_o         = a_q;
  assign reg_x_o         = x_q;
  assign reg_y_o         = y_q;
  assign zero_flag_o     = z_q;
  assign negative_flag_o = n_q;
  assign wrote_memory_o  = wrote_q;
  assign write_address_o = waddr_q;
  assign write_data_o    = wdata_q;
  assign instr_bytes_o   = bytes_q;
  assign cycle_count_o   = cycles_q;
  assign unsupported_o   = unsup_q;

endmodule

// ===== rtl/core/cpu_load_store_addressing_unit.sv =====
// ----------------------------------------------------------------------------
// cpu_load_store_addressing_unit
// Executes one 8-bit CPU load or store per command word over a single-port
// byte memory.
//
//   Channel   Ports                                   Handshake
//   command   opcode_i, mode_i, operand_i             start high, busy low
//   result    reg_a_o .. unsupported_o                done_o for one cycle
//
// The strobe follows the address state for immediate, unsupported and direct
// stores, the load state for direct loads; indirect words read pointer-low and
// pointer-high first, as one memory port serializes pointer and data access.
// A new command may be accepted in the cycle the strobe is shown.
// Reset clears A, X, Y and the flags; memory is undefined until written.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module cpu_load_store_addressing_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  mode_i,
  input  logic [15:0] operand_i,
  output logic        done_o,
  output logic [7:0]  reg_a_o,
  output logic [7:0]  reg_x_o,
  output logic [7:0]  reg_y_o,
  output logic        zero_flag_o,
  output logic        negative_flag_o,
  output logic        wrote_memory_o,
  output logic [15:0] write_address_o,
  output logic [7:0]  write_data_o,
  output logic [1:0]  instr_bytes_o,
  output logic [2:0]  cycle_count_o,
  output logic        unsupported_o
);

  clsau_pkg::mem_req_t mem_req;
  logic [7:0]          mem_rdata;

  clsau_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .mode_i          (mode_i),
    .operand_i       (operand_i),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .done_o          (done_o),
    .reg_a_o         (reg_a_o),
    .reg_x_o         (reg_x_o),
    .reg_y_o         (reg_y_o),
    .zero_flag_o     (zero_flag_o),
    .negative_flag_o (negative_flag_o),
    .wrote_memory_o  (wrote_memory_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .instr_bytes_o   (instr_bytes_o),
    .cycle_count_o   (cycle_count_o),
    .unsupported_o   (unsupported_o)
  );

  clsau_ram #(
    .WIDTH (8),
    .DEPTH (clsau_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/core/clsau_chk.sv =====
// ----------------------------------------------------------------------------
// clsau_chk
// Port-level checks of the load/store addressing unit, bound to the top level.
// ----------------------------------------------------------------------------
module clsau_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        wrote_memory_o,
  input logic [1:0]  instr_bytes_o,
  input logic [2:0]  cycle_count_o,
  input logic        unsupported_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted word did not make the unit busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_unsup_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && unsupported_o) |->
      (!wrote_memory_o && instr_bytes_o == 2'd0 && cycle_count_o == 3'd0))
    else $error("unsupported word reported activity");

  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !unsupported_o) |-> (instr_bytes_o == 2'd2 || instr_bytes_o == 2'd3))
    else $error("bad instruction length");

endmodule

bind cpu_load_store_addressing_unit clsau_chk u_chk (.*);
